@@ hdl/aigsh_pkg.sv @@
package aigsh_pkg;

  // Default sizing of the gate table and of the literal ports
  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int LITERAL_BITS_DEF  = 17;

  // Gate variables are always 16 bits wide
  localparam int VAR_BITS = 16;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_FIRST_FRESH_VAR = '0;
  localparam logic [VAR_BITS-1:0]   FIRST_FRESH_RESET   = 16'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

endpackage

@@ hdl/and_gate_structural_hash_table.sv @@
// Structural hash table for AND gates of an and-inverter graph. Each request asks
// for the AND (opcode 0) or OR (opcode 1) of two signed literals; OR is built as the
// negated AND of the negated operands. The ordered operand pair is looked up in an
// open-addressed table (one single-port-read memory, linear probing from a folded
// hash of the pair). A hit returns the stored gate; a miss stores the pair under the
// next fresh variable, or reports full status if no slot or fresh variable is left;
// zero or most-negative operands are rejected. A request whose first probe decides
// passes accept, hash and read, compare and output load; every collision adds one
// more probe, one read of the table memory. After reset the table is cleared one
// entry per cycle with in_stall high; configuration writes are taken during that pass.
// A new request is taken while the previous result still waits in the output register.
module and_gate_structural_hash_table #(
  parameter int TABLE_ENTRIES = aigsh_pkg::TABLE_ENTRIES_DEF,
  parameter int LITERAL_BITS  = aigsh_pkg::LITERAL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic signed [LITERAL_BITS-1:0]       operand_a,
  input  logic signed [LITERAL_BITS-1:0]       operand_b,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [LITERAL_BITS-1:0]       result_literal,
  output logic                                 gate_created,
  output logic [LITERAL_BITS-1:0]              encoded_literal,
  output logic [1:0]                           status,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [aigsh_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [aigsh_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [aigsh_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready
);

  localparam int VB     = aigsh_pkg::VAR_BITS;
  localparam int LB     = LITERAL_BITS;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int WIDE   = ((LB > VB) ? LB : VB) + 2;
  localparam int KEY_W  = 2 * LB;
  localparam int NCHUNK = (KEY_W + IDX_W - 1) / IDX_W;

  localparam logic [CNT_W:0]     TE_C     = (CNT_W + 1)'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]   TE_CNT   = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [LB-1:0]      MIN_LIT  = {1'b1, {(LB - 1){1'b0}}};
  localparam logic [VB-1:0]      VAR_MIN  = VB'(2);

  typedef struct packed {
    logic                 valid;
    logic signed [LB-1:0] left;
    logic signed [LB-1:0] right;
    logic [VB-1:0]        gate_var;
  } entry_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     clr_addr;
  logic                 req_or;
  logic signed [LB-1:0] req_lo;
  logic signed [LB-1:0] req_hi;
  logic [IDX_W-1:0]     probe_addr;
  logic [CNT_W-1:0]     probe_cnt;
  logic [CNT_W-1:0]     entry_count;
  logic [VB-1:0]        next_fresh_var;
  logic [VB-1:0]        first_fresh_var;
  logic signed [LB-1:0] pend_lit;
  logic                 pend_created;
  logic [LB-1:0]        pend_enc;
  logic [1:0]           pend_status;

  // table memory
  entry_t               mem [TABLE_ENTRIES];
  entry_t               rd_data;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wr_addr;
  entry_t               mem_wr_data;
  logic                 mem_rd_en;
  logic [IDX_W-1:0]     mem_rd_addr;

  // request decode
  logic                 in_accept;
  logic [LB-1:0]        mag_a;
  logic [LB-1:0]        mag_b;
  logic signed [LB-1:0] lit_a;
  logic signed [LB-1:0] lit_b;
  logic                 in_reject;

  // hashing and probing
  logic [IDX_W-1:0]     hash_idx;
  logic [IDX_W-1:0]     probe_next;
  logic                 probe_hit;
  logic                 probe_empty;
  logic                 probe_last;
  logic                 probe_more;
  logic                 fresh_ok;
  logic                 store;

  // result formatting
  logic [VB-1:0]        res_var;
  logic [WIDE-1:0]      res_wide;
  logic [WIDE-1:0]      lit_wide;
  logic [WIDE-1:0]      enc_wide;

  logic                 cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[aigsh_pkg::CFG_ADDR_W-1:2] == aigsh_pkg::REG_FIRST_FRESH_VAR);
  assign prdata    = (paddr[aigsh_pkg::CFG_ADDR_W-1:2] == aigsh_pkg::REG_FIRST_FRESH_VAR)
                     ? aigsh_pkg::CFG_DATA_W'(first_fresh_var) : '0;

  // ---------------------------------------------------------------------------
  // Request decode: reject, OR inversion, order by magnitude
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign mag_a     = operand_a[LB-1] ? -operand_a : operand_a;
  assign mag_b     = operand_b[LB-1] ? -operand_b : operand_b;
  assign lit_a     = opcode ? -operand_a : operand_a;
  assign lit_b     = opcode ? -operand_b : operand_b;
  assign in_reject = (operand_a == '0) || (operand_b == '0)
                     || (operand_a == MIN_LIT) || (operand_b == MIN_LIT);

  // ---------------------------------------------------------------------------
  // Hash: xor-fold the ordered pair to index width, then reduce below the depth
  always_comb begin
    logic [NCHUNK*IDX_W-1:0] key_pad;
    logic [IDX_W-1:0]        fold;
    key_pad = (NCHUNK * IDX_W)'({req_hi, req_lo});
    fold    = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      fold = fold ^ key_pad[i*IDX_W +: IDX_W];
    end
    if ((CNT_W + 1)'(fold) >= TE_C) begin
      hash_idx = IDX_W'((CNT_W + 1)'(fold) - TE_C);
    end else begin
      hash_idx = fold;
    end
  end

  // ---------------------------------------------------------------------------
  // Probe decode on the entry read in the previous cycle
  assign probe_hit   = rd_data.valid && (rd_data.left == req_lo) && (rd_data.right == req_hi);
  assign probe_empty = !rd_data.valid;
  assign probe_last  = ((CNT_W + 1)'(probe_cnt) == TE_C);
  assign probe_more  = (state == ST_PROBE) && rd_data.valid && !probe_hit && !probe_last;
  assign probe_next  = ((CNT_W + 1)'(probe_addr) + 1'b1 == TE_C) ? '0 : probe_addr + 1'b1;
  assign fresh_ok    = (next_fresh_var >= VAR_MIN) && (entry_count < TE_CNT);
  assign store       = (state == ST_PROBE) && probe_empty && fresh_ok;

  // Result literal and its AIGER code; gate variables are always 2 or above
  assign res_var  = probe_hit ? rd_data.gate_var : next_fresh_var;
  assign res_wide = WIDE'(res_var);
  assign lit_wide = req_or ? -res_wide : res_wide;
  assign enc_wide = ((res_wide - 1'b1) << 1) | WIDE'(req_or);

  // ---------------------------------------------------------------------------
  // Memory port control. Writes happen only in the clearing pass and in the
  // compare cycle; the next read is issued in the hash step of a later request, so no forwarding.
  always_comb begin
    mem_we               = (state == ST_CLEAR) || store;
    mem_wr_addr          = (state == ST_CLEAR) ? clr_addr : probe_addr;
    mem_wr_data          = '0;
    if (state != ST_CLEAR) begin
      mem_wr_data.valid    = 1'b1;
      mem_wr_data.left     = req_lo;
      mem_wr_data.right    = req_hi;
      mem_wr_data.gate_var = next_fresh_var;
    end
    mem_rd_en            = (state == ST_HASH) || probe_more;
    mem_rd_addr          = (state == ST_HASH) ? hash_idx : probe_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data <= mem[mem_rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, counters and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      entry_count     <= '0;
      next_fresh_var  <= aigsh_pkg::FIRST_FRESH_RESET;
      first_fresh_var <= aigsh_pkg::FIRST_FRESH_RESET;
      out_valid       <= 1'b0;
    end else begin
      // result taken downstream; the output step reloads it itself
      if (out_valid && !out_stall && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (in_accept) begin
            req_or <= opcode;
            if (mag_a > mag_b) begin
              req_lo <= lit_b;
              req_hi <= lit_a;
            end else begin
              req_lo <= lit_a;
              req_hi <= lit_b;
            end
            if (in_reject) begin
              pend_lit     <= '0;
              pend_created <= 1'b0;
              pend_enc     <= '0;
              pend_status  <= aigsh_pkg::STATUS_REJECT;
              state        <= ST_RESP;
            end else begin
              state <= ST_HASH;
            end
          end
        end

        ST_HASH: begin
          probe_addr <= hash_idx;
          probe_cnt  <= CNT_W'(1);
          state      <= ST_PROBE;
        end

        ST_PROBE: begin
          if (probe_hit || store) begin
            pend_lit     <= lit_wide[LB-1:0];
            pend_created <= store;
            pend_enc     <= enc_wide[LB-1:0];
            pend_status  <= aigsh_pkg::STATUS_OK;
            state        <= ST_RESP;
            if (store) begin
              entry_count    <= entry_count + 1'b1;
              next_fresh_var <= next_fresh_var + 1'b1;
            end
          end else if (probe_empty || probe_last) begin
            // table full or fresh variables exhausted
            pend_lit     <= '0;
            pend_created <= 1'b0;
            pend_enc     <= '0;
            pend_status  <= aigsh_pkg::STATUS_FULL;
            state        <= ST_RESP;
          end else begin
            probe_addr <= probe_next;
            probe_cnt  <= probe_cnt + 1'b1;
          end
        end

        ST_RESP: begin
          if (!out_valid || !out_stall) begin
            result_literal  <= pend_lit;
            gate_created    <= pend_created;
            encoded_literal <= pend_enc;
            status          <= pend_status;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      // register write; the counter follows only while the table is empty
      if (cfg_write) begin
        first_fresh_var <= pwdata[VB-1:0];
        if (entry_count == '0) begin
          next_fresh_var <= pwdata[VB-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= TE_CNT)
    else $error("entry count beyond table depth");

  a_store_empty: assert property (@(posedge clk) disable iff (rst)
    store |-> (!rd_data.valid && next_fresh_var >= VAR_MIN && !probe_hit))
    else $error("store into an occupied slot or without a fresh variable");

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    store |=> (entry_count == $past(entry_count) + 1'b1))
    else $error("entry count did not advance after a store");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (probe_cnt != '0 && (CNT_W + 1)'(probe_cnt) <= TE_C))
    else $error("probe count out of range");

  a_created_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_created) |-> (status == aigsh_pkg::STATUS_OK))
    else $error("new gate reported with a failure status");

endmodule
